>>> hdl/vca_pkg.sv
// Shared types and constants for the velocity command arbiter.
package vca_pkg;

  localparam int OP_WIDTH  = 2;
  localparam int IDX_WIDTH = 3;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_JOY  = 2'd0,
    OP_NAV  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SRC_JOY  = 2'd0,
    SRC_NAV  = 2'd1,
    SRC_STOP = 2'd2
  } src_t;

  typedef struct packed {
    logic halt;
    src_t source;
  } status_t;

  localparam logic [IDX_WIDTH-1:0] REG_MAX_YAW_RATE  = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_MAX_LATERAL   = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_DEADZONE      = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_TIMEOUT_TICKS = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_ROTATE_ASSIST = 3'd4;

  localparam logic [31:0] RST_MAX_YAW_RATE  = 32'd5734;
  localparam logic [31:0] RST_MAX_LATERAL   = 32'd2048;
  localparam logic [31:0] RST_DEADZONE      = 32'd205;
  localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd50;
  localparam logic [31:0] RST_ROTATE_ASSIST = 32'd410;

endpackage

>>> hdl/velocity_command_arbiter.sv
// Top level of the velocity command arbiter: input register, state, result register.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, in_op, in_joy_*, in_nav_*   | to block
//  out     | out_valid/out_ready, out_forward/lateral/yaw,  | from block
//          | out_halt, out_source                           |
//  cfg     | cfg_we, cfg_index, cfg_data                    | to block
//
// A word is taken into the input register; when it advances it is applied to the held state
// and, for a tick, loads the result register, which drives out_* directly. One word per
// cycle while no tick waits, set by the single input register stage.
// Lateral and yaw each take one signed multiply between the input register and the held
// state. A tick in the input register waits while an earlier result is still not taken,
// and the input stalls behind it; nothing else stalls. Reset loads the register defaults,
// clears held velocities and marks the command stale.
module velocity_command_arbiter #(
  parameter int VEL_WIDTH = 16,
  parameter int FRAC_BITS = 12,
  parameter int AGE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [vca_pkg::OP_WIDTH-1:0]           in_op,
  input  logic signed [VEL_WIDTH-1:0]            in_joy_forward,
  input  logic signed [VEL_WIDTH-1:0]            in_joy_lateral,
  input  logic signed [VEL_WIDTH-1:0]            in_joy_yaw,
  input  logic signed [VEL_WIDTH-1:0]            in_nav_forward,
  input  logic signed [VEL_WIDTH-1:0]            in_nav_lateral,
  input  logic signed [VEL_WIDTH-1:0]            in_nav_yaw,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [VEL_WIDTH-1:0]            out_forward,
  output logic signed [VEL_WIDTH-1:0]            out_lateral,
  output logic signed [VEL_WIDTH-1:0]            out_yaw,
  output logic                                   out_halt,
  output logic [1:0]                             out_source,
  input  logic                                   cfg_we,
  input  logic [vca_pkg::IDX_WIDTH-1:0]          cfg_index,
  input  logic [((VEL_WIDTH > AGE_WIDTH) ? VEL_WIDTH : AGE_WIDTH)-1:0] cfg_data
);

  // config registers
  logic        [VEL_WIDTH-2:0] max_yaw_rate_r, max_lateral_r, deadzone_r;
  logic        [AGE_WIDTH-1:0] timeout_ticks_r;
  logic signed [VEL_WIDTH-1:0] rotate_assist_r;

  // input register
  logic                         in_valid_r;
  logic [vca_pkg::OP_WIDTH-1:0] op_r;
  logic signed [VEL_WIDTH-1:0]  joy_f_r, joy_l_r, joy_y_r, nav_f_in_r, nav_l_in_r, nav_y_in_r;

  // held state
  logic signed [VEL_WIDTH-1:0]  held_joy_f_r, held_joy_l_r, held_joy_y_r;
  logic signed [VEL_WIDTH-1:0]  held_nav_f_r, held_nav_l_r, held_nav_y_r;
  logic [AGE_WIDTH-1:0]         age_r, age_nxt;

  // result register
  logic                         out_valid_r;
  logic signed [VEL_WIDTH-1:0]  out_f_r, out_l_r, out_y_r;
  vca_pkg::status_t             out_status_r;

  logic                         in_accept, advance, is_tick, fresh;
  logic signed [VEL_WIDTH-1:0]  scl_f, scl_l, scl_y, sel_f, sel_l, sel_y;
  vca_pkg::status_t             sel_status;

  assign is_tick   = (op_r == vca_pkg::OP_TICK);
  assign advance   = in_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_yaw_rate_r  <= vca_pkg::RST_MAX_YAW_RATE[VEL_WIDTH-2:0];
      max_lateral_r   <= vca_pkg::RST_MAX_LATERAL[VEL_WIDTH-2:0];
      deadzone_r      <= vca_pkg::RST_DEADZONE[VEL_WIDTH-2:0];
      timeout_ticks_r <= vca_pkg::RST_TIMEOUT_TICKS[AGE_WIDTH-1:0];
      rotate_assist_r <= vca_pkg::RST_ROTATE_ASSIST[VEL_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        vca_pkg::REG_MAX_YAW_RATE:  max_yaw_rate_r  <= cfg_data[VEL_WIDTH-2:0];
        vca_pkg::REG_MAX_LATERAL:   max_lateral_r   <= cfg_data[VEL_WIDTH-2:0];
        vca_pkg::REG_DEADZONE:      deadzone_r      <= cfg_data[VEL_WIDTH-2:0];
        vca_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[AGE_WIDTH-1:0];
        vca_pkg::REG_ROTATE_ASSIST: rotate_assist_r <= cfg_data[VEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r       <= in_op;
      joy_f_r    <= in_joy_forward;
      joy_l_r    <= in_joy_lateral;
      joy_y_r    <= in_joy_yaw;
      nav_f_in_r <= in_nav_forward;
      nav_l_in_r <= in_nav_lateral;
      nav_y_in_r <= in_nav_yaw;
    end
  end

  vca_joy_scale #(
    .VEL_WIDTH(VEL_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_joy (
    .joy_forward (joy_f_r),
    .joy_lateral (joy_l_r),
    .joy_yaw     (joy_y_r),
    .max_yaw_rate(max_yaw_rate_r),
    .max_lateral (max_lateral_r),
    .fwd         (scl_f),
    .lat         (scl_l),
    .yaw         (scl_y)
  );

  // age the command, saturating at all ones
  assign age_nxt = (age_r == '1) ? age_r : age_r + 1'b1;
  assign fresh   = (age_nxt < timeout_ticks_r);

  vca_select #(
    .VEL_WIDTH(VEL_WIDTH)
  ) u_sel (
    .joy_fwd      (held_joy_f_r),
    .joy_lat      (held_joy_l_r),
    .joy_yaw      (held_joy_y_r),
    .nav_fwd      (held_nav_f_r),
    .nav_lat      (held_nav_l_r),
    .nav_yaw      (held_nav_y_r),
    .deadzone     (deadzone_r),
    .fresh        (fresh),
    .rotate_assist(rotate_assist_r),
    .fwd          (sel_f),
    .lat          (sel_l),
    .yaw          (sel_y),
    .status       (sel_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_joy_f_r <= '0;
      held_joy_l_r <= '0;
      held_joy_y_r <= '0;
      held_nav_f_r <= '0;
      held_nav_l_r <= '0;
      held_nav_y_r <= '0;
      age_r        <= '1;
    end else if (advance) begin
      case (op_r)
        vca_pkg::OP_JOY: begin
          held_joy_f_r <= scl_f;
          held_joy_l_r <= scl_l;
          held_joy_y_r <= scl_y;
        end
        vca_pkg::OP_NAV: begin
          held_nav_f_r <= nav_f_in_r;
          held_nav_l_r <= nav_l_in_r;
          held_nav_y_r <= nav_y_in_r;
          age_r        <= '0;
        end
        vca_pkg::OP_TICK: begin
          age_r <= age_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tick) begin
      out_f_r      <= sel_f;
      out_l_r      <= sel_l;
      out_y_r      <= sel_y;
      out_status_r <= sel_status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_forward = out_f_r;
  assign out_lateral = out_l_r;
  assign out_yaw     = out_y_r;
  assign out_halt    = out_status_r.halt;
  assign out_source  = out_status_r.source;

  a_nav_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r == vca_pkg::OP_NAV) |=> (age_r == '0))
    else $error("command word did not restart the age counter");

  a_halt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r.halt ==
                     (out_f_r == '0 && out_l_r == '0 && out_y_r == '0)))
    else $error("halt flag disagrees with result velocity");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r.source == vca_pkg::SRC_STOP) |-> out_status_r.halt)
    else $error("stop source without halt");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && is_tick && out_valid_r && !out_ready))
    else $error("input stalled without a pending result");

  a_tick_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_tick) |=> out_valid_r)
    else $error("tick advanced without a result");

endmodule

>>> hdl/vca_joy_scale.sv
// Joystick conditioning: forward clamp, lateral and yaw scaling with limits.
module vca_joy_scale #(
  parameter int VEL_WIDTH = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic signed [VEL_WIDTH-1:0] joy_forward,
  input  logic signed [VEL_WIDTH-1:0] joy_lateral,
  input  logic signed [VEL_WIDTH-1:0] joy_yaw,
  input  logic        [VEL_WIDTH-2:0] max_yaw_rate,
  input  logic        [VEL_WIDTH-2:0] max_lateral,
  output logic signed [VEL_WIDTH-1:0] fwd,
  output logic signed [VEL_WIDTH-1:0] lat,
  output logic signed [VEL_WIDTH-1:0] yaw
);

  localparam int PW = 2 * VEL_WIDTH;
  // unit value, or the largest positive value when 1.0 does not fit
  localparam longint ONE_L = (FRAC_BITS >= VEL_WIDTH - 1) ?
                             ((longint'(1) << (VEL_WIDTH - 1)) - 1) :
                             (longint'(1) << FRAC_BITS);
  localparam logic signed [VEL_WIDTH-1:0] ONE_P = VEL_WIDTH'(ONE_L);
  localparam logic signed [VEL_WIDTH-1:0] ONE_N = -ONE_P;
  localparam logic signed [PW-1:0] VMAX_P =
    {{(PW-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] VMIN_P =
    {{(PW-VEL_WIDTH+1){1'b1}}, {(VEL_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] lat_prod, lat_sh, lat_lim, lat_lim_n;
  logic signed [PW-1:0] yaw_prod, yaw_sh;

  always_comb begin
    if (joy_forward > ONE_P) begin
      fwd = ONE_P;
    end else if (joy_forward < ONE_N) begin
      fwd = ONE_N;
    end else begin
      fwd = joy_forward;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign lat_prod  = PW'(joy_lateral) * $signed({{(PW-VEL_WIDTH+1){1'b0}}, max_lateral});
  assign lat_sh    = lat_prod >>> FRAC_BITS;
  assign lat_lim   = $signed({{(PW-VEL_WIDTH+1){1'b0}}, max_lateral});
  assign lat_lim_n = -lat_lim;

  always_comb begin
    if (lat_sh > lat_lim) begin
      lat = lat_lim[VEL_WIDTH-1:0];
    end else if (lat_sh < lat_lim_n) begin
      lat = lat_lim_n[VEL_WIDTH-1:0];
    end else begin
      lat = lat_sh[VEL_WIDTH-1:0];
    end
  end

  assign yaw_prod = PW'(joy_yaw) * $signed({{(PW-VEL_WIDTH+1){1'b0}}, max_yaw_rate});
  assign yaw_sh   = yaw_prod >>> FRAC_BITS;

  always_comb begin
    if (yaw_sh > VMAX_P) begin
      yaw = VMAX_P[VEL_WIDTH-1:0];
    end else if (yaw_sh < VMIN_P) begin
      yaw = VMIN_P[VEL_WIDTH-1:0];
    end else begin
      yaw = yaw_sh[VEL_WIDTH-1:0];
    end
  end

endmodule

>>> hdl/vca_select.sv
// Source selection on a tick: joystick, fresh autonomous command or stop, plus assist.
module vca_select #(
  parameter int VEL_WIDTH = 16
) (
  input  logic signed [VEL_WIDTH-1:0] joy_fwd,
  input  logic signed [VEL_WIDTH-1:0] joy_lat,
  input  logic signed [VEL_WIDTH-1:0] joy_yaw,
  input  logic signed [VEL_WIDTH-1:0] nav_fwd,
  input  logic signed [VEL_WIDTH-1:0] nav_lat,
  input  logic signed [VEL_WIDTH-1:0] nav_yaw,
  input  logic        [VEL_WIDTH-2:0] deadzone,
  input  logic                        fresh,
  input  logic signed [VEL_WIDTH-1:0] rotate_assist,
  output logic signed [VEL_WIDTH-1:0] fwd,
  output logic signed [VEL_WIDTH-1:0] lat,
  output logic signed [VEL_WIDTH-1:0] yaw,
  output vca_pkg::status_t            status
);

  logic [VEL_WIDTH-1:0] abs_f, abs_l, abs_y;
  logic                 joy_active;
  logic signed [VEL_WIDTH-1:0] pick_f, pick_l, pick_y;
  vca_pkg::src_t        src;

  // magnitude as unsigned, so the most negative value still compares right
  assign abs_f = joy_fwd[VEL_WIDTH-1] ? (~joy_fwd + 1'b1) : joy_fwd;
  assign abs_l = joy_lat[VEL_WIDTH-1] ? (~joy_lat + 1'b1) : joy_lat;
  assign abs_y = joy_yaw[VEL_WIDTH-1] ? (~joy_yaw + 1'b1) : joy_yaw;

  assign joy_active = (abs_f > {1'b0, deadzone}) || (abs_l > {1'b0, deadzone}) ||
                      (abs_y > {1'b0, deadzone});

  always_comb begin
    if (joy_active) begin
      pick_f = joy_fwd;
      pick_l = joy_lat;
      pick_y = joy_yaw;
      src    = vca_pkg::SRC_JOY;
    end else if (fresh) begin
      pick_f = nav_fwd;
      pick_l = nav_lat;
      pick_y = nav_yaw;
      src    = vca_pkg::SRC_NAV;
    end else begin
      pick_f = '0;
      pick_l = '0;
      pick_y = '0;
      src    = vca_pkg::SRC_STOP;
    end
  end

  // pure rotation: add forward assist
  assign fwd = (pick_f == '0 && pick_l == '0 && pick_y != '0) ? rotate_assist : pick_f;
  assign lat = pick_l;
  assign yaw = pick_y;

  assign status.halt   = (fwd == '0) && (pick_l == '0) && (pick_y == '0);
  assign status.source = src;

endmodule
